// File: design/serial_frame_checksum_receiver_defines.svh
// Assertion macros used by the checker of the frame receiver.
`ifndef SERIAL_FRAME_CHECKSUM_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_CHECKSUM_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SFCR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame receiver assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SFCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame receiver assertion failed");

`endif

// File: design/sfcr_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the serial frame checksum receiver.
package sfcr_pkg;

  localparam int unsigned BUF_LEN     = 64;
  localparam int unsigned CHANNELS    = 9;
  localparam int unsigned FRAME_LEN   = 4 * CHANNELS + 5;
  localparam int unsigned HIST_LEN    = FRAME_LEN - 1;
  localparam int unsigned CNT_W       = $clog2(BUF_LEN + 1);
  localparam int unsigned CH_W        = 4;
  localparam int unsigned IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] HDR_B0 = 8'hFF;
  localparam logic [7:0] HDR_B1 = 8'h55;
  localparam logic [7:0] HDR_B2 = 8'hAA;
  localparam logic [7:0] HDR_B3 = 8'h10;

  localparam logic [31:0]       POS_MAX = 32'h7FFF_FFFF;
  localparam logic [CH_W-1:0]   LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(CHANNELS - 1);

  typedef logic [CHANNELS-1:0][31:0] frame_t;

  // Frame handed from the front to the queue.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_push_t;

  // Oldest queued frame as seen by the back part.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } q_head_t;

endpackage

// File: design/sfcr_front.sv
`timescale 1ns / 1ps
// Byte front end: counts bytes, keeps the byte window and its sum, detects frames.
module sfcr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output sfcr_pkg::q_push_t   push_o
);

  logic [sfcr_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 hist_q [sfcr_pkg::HIST_LEN];
  logic                       buf_full;
  logic                       hdr_hit;
  logic                       sum_ok;

  assign buf_full = count_q >= sfcr_pkg::CNT_W'(sfcr_pkg::BUF_LEN);
  // Incremented count covers a full frame when the old count is FRAME_LEN-1 or more.
  assign hdr_hit  = (count_q >= sfcr_pkg::CNT_W'(sfcr_pkg::FRAME_LEN - 1)) &&
                    (hist_q[0] == sfcr_pkg::HDR_B0) && (hist_q[1] == sfcr_pkg::HDR_B1) &&
                    (hist_q[2] == sfcr_pkg::HDR_B2) && (hist_q[3] == sfcr_pkg::HDR_B3);
  assign sum_ok   = sum_q == rx_byte_i;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (accept_i) begin
      if (buf_full) begin
        count_d = '0;
      end else begin
        count_d = hdr_hit ? '0 : count_q + 1'b1;
        sum_d   = sum_q - hist_q[0] + rx_byte_i;
      end
    end
  end

  always_comb begin
    push_o.valid = accept_i && !buf_full && hdr_hit && sum_ok;
    for (int i = 0; i < sfcr_pkg::CHANNELS; i++) begin
      push_o.frame[i] = {hist_q[4 + 4 * i], hist_q[5 + 4 * i],
                         hist_q[6 + 4 * i], hist_q[7 + 4 * i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  // Window starts at zero so that the running sum matches its contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfcr_pkg::HIST_LEN; i++) begin
        hist_q[i] <= '0;
      end
    end else if (accept_i && !buf_full) begin
      for (int i = 0; i < sfcr_pkg::HIST_LEN - 1; i++) begin
        hist_q[i] <= hist_q[i + 1];
      end
      hist_q[sfcr_pkg::HIST_LEN - 1] <= rx_byte_i;
    end
  end

endmodule

// File: design/sfcr_queue.sv
`timescale 1ns / 1ps
// Short frame queue between the byte front end and the result sequencer.
module sfcr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfcr_pkg::q_push_t push_i,
  input  logic              pop_i,
  output sfcr_pkg::q_head_t head_o,
  output logic              full_o
);

  sfcr_pkg::frame_t            mem_q [sfcr_pkg::QUEUE_DEPTH];
  logic [sfcr_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [sfcr_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [sfcr_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        do_push;
  logic                        do_pop;

  assign full_o       = cnt_q == sfcr_pkg::QCNT_W'(sfcr_pkg::QUEUE_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.frame = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == sfcr_pkg::QPTR_W'(sfcr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == sfcr_pkg::QPTR_W'(sfcr_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

endmodule

// File: design/sfcr_back.sv
`timescale 1ns / 1ps
// Result sequencer: walks the channels of the oldest frame into the output register.
module sfcr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfcr_pkg::q_head_t           head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sfcr_pkg::CH_W-1:0]   channel_o,
  output logic signed [31:0]          channel_value_o,
  output logic                        last_channel_o
);

  logic [sfcr_pkg::IDX_W-1:0] idx_q, idx_d;
  logic                       valid_q, valid_d;
  logic [sfcr_pkg::CH_W-1:0]  chan_q;
  logic [31:0]                value_q;
  logic                       last_q;
  logic                       load;
  logic                       is_last;
  logic [31:0]                word;
  logic [31:0]                mapped;

  // Refill the output register when it is empty or being taken.
  assign load    = head_i.valid && (!valid_q || out_ready_i);
  assign is_last = idx_q == sfcr_pkg::LAST_IDX;
  assign pop_o   = load && is_last;
  assign word    = head_i.frame[idx_q];
  assign mapped  = word[31] ? sfcr_pkg::POS_MAX - word : word;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = is_last ? '0 : idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      chan_q  <= sfcr_pkg::CH_W'(idx_q);
      value_q <= mapped;
      last_q  <= is_last;
    end
  end

  assign out_valid_o     = valid_q;
  assign channel_o       = chan_q;
  assign channel_value_o = value_q;
  assign last_channel_o  = last_q;

endmodule

// File: design/serial_frame_checksum_receiver.sv
`timescale 1ns / 1ps
// Top level of the serial frame checksum receiver.
// Input channel: in_valid_i / in_ready_o carry one received byte (rx_byte_i) per item.
// A byte is taken every cycle while the frame queue has room; ready drops only
// when two checked frames are queued and not yet walked out.
// Output channel: out_valid_o / out_ready_i carry one decoded channel per item:
// channel_o, channel_value_o (signed 16.16) and last_channel_o on the final one.
// When the checksum byte that closes a good frame is accepted, the frame enters the
// queue at that edge; its first result is loaded into the output register once that
// register is empty or being taken. The remaining channels follow one per cycle while
// the receiver takes them, set by the single output register the sequencer refills.
// Throughput: one byte per cycle on input while the queue has room; one result per
// cycle on output while the receiver takes them. A frame needs at least 4*CHANNELS+5
// bytes, so the back part keeps up with a steady byte stream unless the receiver stalls.
// Reset clears the byte count, the running sum, the byte window and the queue;
// no results are pending afterwards.
// A stalled receiver holds the current result; bytes keep flowing until the
// queue fills, then in_ready_o stays low until a frame has been drained.
module serial_frame_checksum_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sfcr_pkg::CH_W-1:0]   channel_o,
  output logic signed [31:0]          channel_value_o,
  output logic                        last_channel_o
);

  sfcr_pkg::q_push_t push;
  sfcr_pkg::q_head_t head;
  logic              pop;
  logic              q_full;
  logic              accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  sfcr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push)
  );

  sfcr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .full_o (q_full)
  );

  sfcr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .channel_o       (channel_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

// File: design/sfcr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the frame receiver, bound to the top level.
`include "serial_frame_checksum_receiver_defines.svh"

module sfcr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sfcr_pkg::CH_W-1:0]   channel_o,
  input logic signed [31:0]          channel_value_o,
  input logic                        last_channel_o
);

  logic                        out_stall;
  logic                        mid_take;
  logic                        is_last_ch;
  logic [sfcr_pkg::CH_W-1:0]   chan_next;
  logic [sfcr_pkg::CH_W+32:0]  res_bus;

  assign out_stall  = out_valid_o && !out_ready_i;
  assign mid_take   = out_valid_o && out_ready_i && !last_channel_o;
  assign is_last_ch = channel_o == sfcr_pkg::LAST_CH;
  assign chan_next  = channel_o + 1'b1;
  assign res_bus    = {channel_o, channel_value_o, last_channel_o};

  // A stalled result holds.
  `SFCR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(res_bus))

  // Channel index stays inside the frame.
  `SFCR_ASSERT_NOW(a_chan_range, clk_i, rst_ni, out_valid_o, channel_o <= sfcr_pkg::LAST_CH)

  // The last flag marks exactly the final channel.
  `SFCR_ASSERT_NOW(a_last_flag, clk_i, rst_ni, out_valid_o, last_channel_o == is_last_ch)

  // Within a frame the channels come in order with no gap.
  `SFCR_ASSERT_NEXT(a_order, clk_i, rst_ni, mid_take, !out_valid_o || channel_o == $past(chan_next))

endmodule

bind serial_frame_checksum_receiver sfcr_checker u_sfcr_checker (.*);
